// ===== src/ledser_pkg.sv =====
package ledser_pkg;

  localparam int MAX_LEDS = 256;
  localparam int ADDR_W   = $clog2(MAX_LEDS);
  localparam int CNT_W    = 9;
  localparam int IDX_W    = 10;
  localparam int PIX_W    = 24;
  localparam int TICK_W   = 16;
  localparam int CFG_W    = 16;
  localparam int REG_W    = 3;

  localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(MAX_LEDS);

  // Item modes.
  localparam logic [2:0] MODE_TICK       = 3'd0;
  localparam logic [2:0] MODE_WRITE      = 3'd1;
  localparam logic [2:0] MODE_WRITE_SHOW = 3'd2;
  localparam logic [2:0] MODE_SHOW       = 3'd3;
  localparam logic [2:0] MODE_CLEAR_SHOW = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_BUSY  = 2'd2;

  // Pulse phases of the serializer.
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_HIGH  = 2'd1;
  localparam logic [1:0] PH_LOW   = 2'd2;
  localparam logic [1:0] PH_LATCH = 2'd3;

  // Configuration register indexes.
  localparam logic [REG_W-1:0] REG_LED_COUNT = 3'd0;
  localparam logic [REG_W-1:0] REG_ZERO_HIGH = 3'd1;
  localparam logic [REG_W-1:0] REG_ZERO_LOW  = 3'd2;
  localparam logic [REG_W-1:0] REG_ONE_HIGH  = 3'd3;
  localparam logic [REG_W-1:0] REG_ONE_LOW   = 3'd4;
  localparam logic [REG_W-1:0] REG_LATCH_LOW = 3'd5;

  localparam logic [2:0] BIT_FIRST = 3'd7;
  localparam logic [1:0] SLOT_LAST = 2'd2;

  typedef struct packed {
    logic accept;
    logic exec;
    logic fetch;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic need_fetch;
  } sts_t;

  // Store layout is red 23..16, green 15..8, blue 7..0; the wire order is
  // green, red, blue.
  function automatic logic pixel_bit(input logic [PIX_W-1:0] px,
                                     input logic [1:0] slot,
                                     input logic [2:0] pos);
    logic [7:0] colour_byte;
    unique case (slot)
      2'd0:    colour_byte = px[15:8];
      2'd1:    colour_byte = px[23:16];
      default: colour_byte = px[7:0];
    endcase
    return colour_byte[pos];
  endfunction

  function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
    return (v == '0) ? TICK_W'(1) : v;
  endfunction

endpackage

// ===== src/ledser_store.sv =====
module ledser_store (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [ledser_pkg::ADDR_W-1:0]      wr_addr,
  input  logic [ledser_pkg::PIX_W-1:0]       wr_data,
  input  logic                               clr_en,
  input  logic [ledser_pkg::CNT_W-1:0]       clr_count,
  input  logic                               rd_en,
  input  logic [ledser_pkg::ADDR_W-1:0]      rd_addr,
  output logic [ledser_pkg::PIX_W-1:0]       rd_data,
  output logic                               rd_mark
);

  logic [ledser_pkg::PIX_W-1:0] mem [ledser_pkg::MAX_LEDS];
  logic [ledser_pkg::MAX_LEDS-1:0] marks;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Flop marks: reset clears all, clr_en those below clr_count, at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      marks   <= '0;
      rd_mark <= 1'b0;
    end else begin
      if (wr_en) begin
        marks[wr_addr] <= 1'b1;
      end
      if (clr_en) begin
        for (int i = 0; i < ledser_pkg::MAX_LEDS; i++) begin
          if (ledser_pkg::CNT_W'(i) < clr_count) begin
            marks[i] <= 1'b0;
          end
        end
      end
      if (rd_en) begin
        rd_mark <= marks[rd_addr];
      end
    end
  end

endmodule

// ===== src/ledser_ctrl.sv =====
module ledser_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ledser_pkg::sts_t  sts,
  output ledser_pkg::cmd_t  cmd,
  output logic              busy
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_FETCH = 2'd2;
  localparam logic [1:0] S_LOAD  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (start) state_next = S_EXEC;
      S_EXEC:  state_next = sts.need_fetch ? S_FETCH : S_IDLE;
      S_FETCH: state_next = S_LOAD;
      S_LOAD:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy       = (state != S_IDLE);
  assign cmd.accept = start && (state == S_IDLE);
  assign cmd.exec   = (state == S_EXEC);
  assign cmd.fetch  = (state == S_FETCH);
  assign cmd.load   = (state == S_LOAD);

endmodule

// ===== src/ledser_dp.sv =====
module ledser_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  ledser_pkg::cmd_t              cmd,
  output ledser_pkg::sts_t              sts,
  input  logic                          cfg_write,
  input  logic [ledser_pkg::REG_W-1:0]  cfg_index,
  input  logic [ledser_pkg::CFG_W-1:0]  cfg_data,
  input  logic [2:0]                    mode,
  input  logic [ledser_pkg::IDX_W-1:0]  led_index,
  input  logic [7:0]                    red,
  input  logic [7:0]                    green,
  input  logic [7:0]                    blue,
  output logic                          strobe,
  output logic                          data_line,
  output logic [1:0]                    status,
  output logic                          busy_res,
  output logic                          frame_done
);

  // Configuration registers.
  logic [ledser_pkg::CNT_W-1:0]  led_count;
  logic [7:0]                    zero_high_ticks;
  logic [7:0]                    zero_low_ticks;
  logic [7:0]                    one_high_ticks;
  logic [7:0]                    one_low_ticks;
  logic [ledser_pkg::TICK_W-1:0] latch_low_ticks;

  // Latched item.
  logic [2:0]                    in_mode;
  logic [ledser_pkg::IDX_W-1:0]  in_idx;
  logic [ledser_pkg::PIX_W-1:0]  in_pix;

  // Serializer state.
  logic                          sending,      sending_next;
  logic [ledser_pkg::CNT_W-1:0]  current_led,  current_led_next;
  logic [1:0]                    colour_slot,  colour_slot_next;
  logic [2:0]                    bit_position, bit_position_next;
  logic [1:0]                    pulse_phase,  pulse_phase_next;
  logic [ledser_pkg::TICK_W-1:0] phase_ticks,  phase_ticks_next;
  logic [ledser_pkg::PIX_W-1:0]  cur_px,       cur_px_next;

  logic                          line_next;
  logic [1:0]                    status_next;
  logic                          done_next;
  logic                          need_fetch;
  logic                          wr_en;
  logic                          clr_en;
  logic [ledser_pkg::CNT_W-1:0]  count;
  logic                          bit_cur;
  logic [ledser_pkg::TICK_W-1:0] ticks_dec;
  logic [ledser_pkg::PIX_W-1:0]  rd_data;
  logic                          rd_mark;
  logic [ledser_pkg::PIX_W-1:0]  load_px;
  logic                          is_write;

  assign count = (led_count > ledser_pkg::COUNT_MAX) ? ledser_pkg::COUNT_MAX : led_count;
  assign bit_cur  = ledser_pkg::pixel_bit(cur_px, colour_slot, bit_position);
  assign load_px  = rd_mark ? rd_data : '0;
  assign is_write = (in_mode == ledser_pkg::MODE_WRITE) ||
                    (in_mode == ledser_pkg::MODE_WRITE_SHOW);
  assign ticks_dec = (phase_ticks != '0) ? phase_ticks - 1'b1 : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      led_count       <= '0;
      zero_high_ticks <= 8'd24;
      zero_low_ticks  <= 8'd52;
      one_high_ticks  <= 8'd49;
      one_low_ticks   <= 8'd27;
      latch_low_ticks <= 16'd4800;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ledser_pkg::REG_LED_COUNT: led_count       <= cfg_data[ledser_pkg::CNT_W-1:0];
        ledser_pkg::REG_ZERO_HIGH: zero_high_ticks <= cfg_data[7:0];
        ledser_pkg::REG_ZERO_LOW:  zero_low_ticks  <= cfg_data[7:0];
        ledser_pkg::REG_ONE_HIGH:  one_high_ticks  <= cfg_data[7:0];
        ledser_pkg::REG_ONE_LOW:   one_low_ticks   <= cfg_data[7:0];
        ledser_pkg::REG_LATCH_LOW: latch_low_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_mode <= mode;
      in_idx  <= led_index;
      in_pix  <= {red, green, blue};
    end
  end

  always_comb begin
    sending_next      = sending;
    current_led_next  = current_led;
    colour_slot_next  = colour_slot;
    bit_position_next = bit_position;
    pulse_phase_next  = pulse_phase;
    phase_ticks_next  = phase_ticks;
    cur_px_next       = cur_px;
    line_next         = 1'b0;
    status_next       = ledser_pkg::ST_OK;
    done_next         = 1'b0;
    need_fetch        = 1'b0;
    wr_en             = 1'b0;
    clr_en            = 1'b0;

    if (cmd.exec) begin
      unique case (in_mode)
        ledser_pkg::MODE_TICK: begin
          if (sending && (pulse_phase != ledser_pkg::PH_IDLE)) begin
            line_next = (pulse_phase == ledser_pkg::PH_HIGH);
            if (ticks_dec != '0) begin
              phase_ticks_next = ticks_dec;
            end else begin
              unique case (pulse_phase)
                ledser_pkg::PH_HIGH: begin
                  pulse_phase_next = ledser_pkg::PH_LOW;
                  phase_ticks_next = ledser_pkg::at_least_one(ledser_pkg::TICK_W'(
                      bit_cur ? one_low_ticks : zero_low_ticks));
                end
                ledser_pkg::PH_LOW: begin
                  if (bit_position != '0) begin
                    bit_position_next = bit_position - 1'b1;
                  end else begin
                    bit_position_next = ledser_pkg::BIT_FIRST;
                    if (colour_slot >= ledser_pkg::SLOT_LAST) begin
                      colour_slot_next = '0;
                      current_led_next = current_led + 1'b1;
                    end else begin
                      colour_slot_next = colour_slot + 1'b1;
                    end
                  end
                  if (current_led_next >= count) begin
                    pulse_phase_next = ledser_pkg::PH_LATCH;
                    phase_ticks_next = ledser_pkg::at_least_one(latch_low_ticks);
                  end else if (current_led_next != current_led) begin
                    need_fetch = 1'b1;
                  end else begin
                    pulse_phase_next = ledser_pkg::PH_HIGH;
                    phase_ticks_next = ledser_pkg::at_least_one(ledser_pkg::TICK_W'(
                        ledser_pkg::pixel_bit(cur_px, colour_slot_next, bit_position_next)
                        ? one_high_ticks : zero_high_ticks));
                  end
                end
                ledser_pkg::PH_LATCH: begin
                  sending_next      = 1'b0;
                  pulse_phase_next  = ledser_pkg::PH_IDLE;
                  current_led_next  = '0;
                  colour_slot_next  = '0;
                  bit_position_next = ledser_pkg::BIT_FIRST;
                  done_next         = 1'b1;
                end
                default: ;
              endcase
            end
          end
        end
        ledser_pkg::MODE_WRITE, ledser_pkg::MODE_WRITE_SHOW,
        ledser_pkg::MODE_SHOW, ledser_pkg::MODE_CLEAR_SHOW: begin
          if (sending) begin
            status_next = ledser_pkg::ST_BUSY;
          end else if (is_write && (in_idx >= {1'b0, count})) begin
            status_next = ledser_pkg::ST_RANGE;
          end else begin
            wr_en  = is_write;
            clr_en = (in_mode == ledser_pkg::MODE_CLEAR_SHOW);
            if (in_mode != ledser_pkg::MODE_WRITE) begin
              sending_next      = 1'b1;
              current_led_next  = '0;
              colour_slot_next  = '0;
              bit_position_next = ledser_pkg::BIT_FIRST;
              if (count == '0) begin
                pulse_phase_next = ledser_pkg::PH_LATCH;
                phase_ticks_next = ledser_pkg::at_least_one(latch_low_ticks);
              end else begin
                need_fetch = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end

    if (cmd.load) begin
      cur_px_next      = load_px;
      pulse_phase_next = ledser_pkg::PH_HIGH;
      phase_ticks_next = ledser_pkg::at_least_one(ledser_pkg::TICK_W'(
          ledser_pkg::pixel_bit(load_px, colour_slot, bit_position)
          ? one_high_ticks : zero_high_ticks));
    end
  end

  assign sts.need_fetch = need_fetch;

  always_ff @(posedge clk) begin
    if (rst) begin
      sending      <= 1'b0;
      current_led  <= '0;
      colour_slot  <= '0;
      bit_position <= ledser_pkg::BIT_FIRST;
      pulse_phase  <= ledser_pkg::PH_IDLE;
      phase_ticks  <= '0;
      strobe       <= 1'b0;
    end else begin
      sending      <= sending_next;
      current_led  <= current_led_next;
      colour_slot  <= colour_slot_next;
      bit_position <= bit_position_next;
      pulse_phase  <= pulse_phase_next;
      phase_ticks  <= phase_ticks_next;
      strobe       <= (cmd.exec && !need_fetch) || cmd.load;
    end
  end

  always_ff @(posedge clk) begin
    cur_px <= cur_px_next;
    if (cmd.exec) begin
      data_line  <= line_next;
      status     <= status_next;
      busy_res   <= sending_next;
      frame_done <= done_next;
    end
  end

  ledser_store u_store (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_addr   (in_idx[ledser_pkg::ADDR_W-1:0]),
    .wr_data   (in_pix),
    .clr_en    (clr_en),
    .clr_count (count),
    .rd_en     (cmd.fetch),
    .rd_addr   (current_led[ledser_pkg::ADDR_W-1:0]),
    .rd_data   (rd_data),
    .rd_mark   (rd_mark)
  );

endmodule

// ===== src/addressable_led_frame_serializer.sv =====
// Addressable LED strip driver with a 256-entry pixel store.
// Items are issued as commands: an item is taken at a rising edge with start
// high and busy low. The mode selects tick, pixel write, write and show,
// show, or clear and show; each item yields exactly one transaction on the
// result ports, marked by strobe for one cycle. The receiver cannot hold
// results off, so every strobe cycle must be captured.
// Configuration registers are written through cfg_write, cfg_index and
// cfg_data; the user must write them only while no item is in flight, which
// the block does not enforce. Indexes beyond the list are ignored. The
// result strobe is registered in the execute step, or, when the item must
// fetch a pixel (a frame start, or a tick that crosses into the next LED),
// in the load step after the fetch step. No item is taken while busy is high.
// Busy stays high from acceptance until the result is registered.
// Reset is synchronous: it clears all written marks at once, returns the
// timing registers to their defaults and idles the serializer. Pixel data
// itself is not cleared; an unmarked entry reads as zero.
module addressable_led_frame_serializer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    mode,
  input  logic [ledser_pkg::IDX_W-1:0]  led_index,
  input  logic [7:0]                    red,
  input  logic [7:0]                    green,
  input  logic [7:0]                    blue,
  input  logic                          cfg_write,
  input  logic [ledser_pkg::REG_W-1:0]  cfg_index,
  input  logic [ledser_pkg::CFG_W-1:0]  cfg_data,
  output logic                          strobe,
  output logic                          data_line,
  output logic [1:0]                    status,
  output logic                          busy_res,
  output logic                          frame_done
);

  // The controller sequences accept, execute, fetch and load steps; the
  // datapath reports back whether an item needs a pixel fetch.
  ledser_pkg::cmd_t cmd;
  ledser_pkg::sts_t sts;

  ledser_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  ledser_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mode       (mode),
    .led_index  (led_index),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .strobe     (strobe),
    .data_line  (data_line),
    .status     (status),
    .busy_res   (busy_res),
    .frame_done (frame_done)
  );

endmodule
